/* sv/fccm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fccm_pkg: shared types and constants of the FAT cluster chain manager
// Request and result payloads, opcodes and table entry markers.
// ----------------------------------------------------------------------------
package fccm_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_LINK  = 2'd1,
    OP_FREE  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [11:0] cluster;
    logic [15:0] next_value;
  } in_t;

  typedef struct packed {
    logic [11:0] result_cluster;
    logic        no_space;
  } out_t;

  localparam logic [15:0] MARK_FREE  = 16'h0000;
  localparam logic [15:0] MARK_END   = 16'hFFFF;
  localparam logic [15:0] MARK_BOOT  = 16'hFFFD;
  localparam logic [15:0] MARK_TABLE = 16'hFFFE;

  // Allocation scans upward from this cluster
  localparam int unsigned FIRST_ALLOC = 10;

endpackage : fccm_pkg
`default_nettype wire

/* sv/fat_cluster_chain_manager.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fat_cluster_chain_manager: file-allocation table with allocate/link/free
// Table lives in one synchronous RAM (one write port, one read port).
// Results: link, no-op and a free that does nothing give their result in the cycle
//   after start; allocate reads one table entry per cycle, scanning upward
//   from FIRST_ALLOC; free follows the chain and clears each entry as it goes.
// One transaction at a time; busy is high while an operation runs.
// Reset: an initialisation pass writes the reset value of every entry, with busy
//   high. The result is a one-cycle out_valid strobe; no stall from receiver.
// ----------------------------------------------------------------------------
module fat_cluster_chain_manager #(
  parameter int unsigned CLUSTER_COUNT           = 4096,
  parameter int unsigned RESERVED_TABLE_CLUSTERS = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire fccm_pkg::in_t in_data,
  output logic               out_valid,
  output fccm_pkg::out_t     out_data
);

  localparam int unsigned IDX_W  = $clog2(CLUSTER_COUNT);
  localparam int unsigned STEP_W = $clog2(CLUSTER_COUNT + 1);

  localparam logic [16:0]       CNT       = 17'(CLUSTER_COUNT);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(CLUSTER_COUNT - 1);
  localparam logic [IDX_W-1:0]  FIRST_IDX = IDX_W'(fccm_pkg::FIRST_ALLOC);
  localparam logic [STEP_W-1:0] STEP_MAX  = STEP_W'(CLUSTER_COUNT);
  localparam logic [16:0]       RES_LAST  = 17'(RESERVED_TABLE_CLUSTERS);
  localparam logic [16:0]       ROOT_IDX  = 17'(RESERVED_TABLE_CLUSTERS + 1);

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_ALLOC,
    ST_FREE
  } state_t;

  function automatic logic [15:0] reset_entry(input logic [IDX_W-1:0] idx);
    logic [16:0] a;
    logic [15:0] v;
    a = 17'(idx);
    if (a == 17'd0) begin
      v = fccm_pkg::MARK_BOOT;
    end else if (a <= RES_LAST) begin
      v = fccm_pkg::MARK_TABLE;
    end else if (a == ROOT_IDX) begin
      v = fccm_pkg::MARK_END;
    end else begin
      v = fccm_pkg::MARK_FREE;
    end
    return v;
  endfunction

  // Table RAM
  logic [15:0] mem [CLUSTER_COUNT];
  logic [15:0] mem_q_r;

  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [15:0]      wdata;
  logic             re;
  logic [IDX_W-1:0] raddr;

  // Forward a write that hits the entry read in the same cycle
  logic        fwd_r;
  logic [15:0] fwd_data_r;
  logic [15:0] rd_data;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  init_addr_r, init_addr_nxt;
  logic [IDX_W-1:0]  chk_addr_r, chk_addr_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic              out_valid_r, out_valid_nxt;
  fccm_pkg::out_t    out_data_r, out_data_nxt;

  logic [15:0]       cl16;
  logic [16:0]       cl17;
  logic [15:0]       grant16;
  logic [STEP_W-1:0] steps_inc;

  assign rd_data   = fwd_r ? fwd_data_r : mem_q_r;
  assign cl16      = 16'(in_data.cluster);
  assign cl17      = 17'(in_data.cluster);
  assign grant16   = 16'(chk_addr_r);
  assign steps_inc = steps_r + STEP_W'(1);

  always_comb begin
    state_nxt     = state_r;
    init_addr_nxt = init_addr_r;
    chk_addr_nxt  = chk_addr_r;
    cur_nxt       = cur_r;
    steps_nxt     = steps_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    re            = 1'b0;
    raddr         = '0;

    case (state_r)
      ST_INIT: begin
        we    = 1'b1;
        waddr = init_addr_r;
        wdata = reset_entry(init_addr_r);
        if (init_addr_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end else begin
          init_addr_nxt = init_addr_r + IDX_W'(1);
        end
      end

      ST_IDLE: begin
        if (start) begin
          out_data_nxt = '0;
          case (fccm_pkg::opcode_t'(in_data.opcode))
            fccm_pkg::OP_ALLOC: begin
              re           = 1'b1;
              raddr        = FIRST_IDX;
              chk_addr_nxt = FIRST_IDX;
              state_nxt    = ST_ALLOC;
            end
            fccm_pkg::OP_LINK: begin
              if (cl17 < CNT) begin
                we    = 1'b1;
                waddr = cl16[IDX_W-1:0];
                wdata = in_data.next_value;
              end
              out_valid_nxt = 1'b1;
            end
            fccm_pkg::OP_FREE: begin
              if (cl16 != fccm_pkg::MARK_FREE && cl17 < CNT) begin
                re        = 1'b1;
                raddr     = cl16[IDX_W-1:0];
                cur_nxt   = cl16[IDX_W-1:0];
                steps_nxt = '0;
                state_nxt = ST_FREE;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_ALLOC: begin
        if (rd_data == fccm_pkg::MARK_FREE) begin
          we            = 1'b1;
          waddr         = chk_addr_r;
          wdata         = fccm_pkg::MARK_END;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{result_cluster: grant16[11:0], no_space: 1'b0};
          state_nxt     = ST_IDLE;
        end else if (chk_addr_r == LAST_IDX) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{result_cluster: 12'd0, no_space: 1'b1};
          state_nxt     = ST_IDLE;
        end else begin
          re           = 1'b1;
          raddr        = chk_addr_r + IDX_W'(1);
          chk_addr_nxt = chk_addr_r + IDX_W'(1);
        end
      end

      ST_FREE: begin
        // Clear the current entry and follow its link in the same cycle
        we    = 1'b1;
        waddr = cur_r;
        wdata = fccm_pkg::MARK_FREE;
        if (rd_data == fccm_pkg::MARK_END || rd_data == fccm_pkg::MARK_FREE ||
            steps_inc >= STEP_MAX || {1'b0, rd_data} >= CNT) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          re        = 1'b1;
          raddr     = rd_data[IDX_W-1:0];
          cur_nxt   = rd_data[IDX_W-1:0];
          steps_nxt = steps_inc;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      mem_q_r <= mem[raddr];
    end
    fwd_data_r <= wdata;
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    chk_addr_r <= chk_addr_nxt;
    cur_r      <= cur_nxt;
    steps_r    <= steps_nxt;
    if (!rst_n) begin
      state_r     <= ST_INIT;
      init_addr_r <= '0;
      out_valid_r <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_addr_r <= init_addr_nxt;
      out_valid_r <= out_valid_nxt;
      fwd_r       <= re && we && (raddr == waddr);
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule : fat_cluster_chain_manager
`default_nettype wire
